// File: sv/vn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_pkg
// Shared constants of the vector normalize block.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int NUM_LANES  = 4;   // component ports on the top level
  localparam int IN_WIDTH   = 32;
  localparam int OUT_WIDTH  = 32;
  localparam int LEN_WIDTH  = 33;
  localparam int CNT_WIDTH  = 3;
  localparam int MIN_COUNT  = 2;
  localparam int MAX_COUNT  = 4;
  // unit result is q = isqrt(floor(mag^2 * 2^60 / s)), quotient <= 2^60
  localparam int QUO_BITS   = 61;

endpackage

// File: sv/vn_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_div_cell
// One restoring division step: shifts a zero into the partial remainder,
// subtracts the divisor when it fits and appends one quotient bit.
// ----------------------------------------------------------------------------
module vn_div_cell #(
  parameter int SW = 65,
  parameter int QB = 61
) (
  input  logic          clk_i,
  input  logic [SW-1:0] rem_i,
  input  logic [QB-1:0] quo_i,
  input  logic [SW-1:0] div_i,
  output logic [SW-1:0] rem_o,
  output logic [QB-1:0] quo_o,
  output logic [SW-1:0] div_o
);

  logic [SW:0]   shifted;
  logic [SW:0]   diff;
  logic          fits;
  logic [SW-1:0] rem_d;
  logic [QB-1:0] quo_d;

  always_comb begin
    shifted = {rem_i, 1'b0};
    diff    = shifted - {1'b0, div_i};
    fits    = shifted >= {1'b0, div_i};
    // remainder stays below the divisor, so the top bit drops safely
    rem_d   = fits ? diff[SW-1:0] : shifted[SW-1:0];
    quo_d   = {quo_i[QB-2:0], fits};
  end

  always_ff @(posedge clk_i) begin
    rem_o <= rem_d;
    quo_o <= quo_d;
    div_o <= div_i;
  end

endmodule

// File: sv/vn_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_sqrt_cell
// One digit step of the restoring integer square root: brings down two
// radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module vn_sqrt_cell #(
  parameter int NB = 33
) (
  input  logic            clk_i,
  input  logic [2*NB-1:0] rad_i,
  input  logic [NB+1:0]   rem_i,
  input  logic [NB-1:0]   root_i,
  output logic [2*NB-1:0] rad_o,
  output logic [NB+1:0]   rem_o,
  output logic [NB-1:0]   root_o
);

  logic [NB+1:0]   cur;
  logic [NB+1:0]   trial;
  logic            fits;
  logic [NB+1:0]   rem_d;
  logic [NB-1:0]   root_d;
  logic [2*NB-1:0] rad_d;

  always_comb begin
    // remainder is at most twice the partial root, so NB bits hold it
    cur    = {rem_i[NB-1:0], rad_i[2*NB-1:2*NB-2]};
    trial  = {root_i, 2'b01};
    fits   = cur >= trial;
    rem_d  = fits ? (cur - trial) : cur;
    root_d = {root_i[NB-2:0], fits};
    rad_d  = {rad_i[2*NB-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    rad_o  <= rad_d;
    rem_o  <= rem_d;
    root_o <= root_d;
  end

endmodule

// File: sv/vector_normalize_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_normalize_top
// Unit vector and magnitude of a 2 to 4 component Q16.16 vector.
// ----------------------------------------------------------------------------
// Usage:
//   A vector is taken at a rising edge with start high and busy low. busy
//   is always low, so a new vector may be given in every cycle.
//   component_count_i selects 2, 3 or 4 components; below 2 counts as 2,
//   above the lane count as the lane count.
//   Each result shows on the output ports for one cycle with done_o high.
//   A transfer passes the magnitude register, which loads at the transfer
//   edge, then the square, pair sum and total registers, one division
//   stage per quotient bit, one square root cell per root bit and the
//   output register. One vector per cycle is sustained; every lane is a
//   chain of cells that hands its partial result on in each cycle.
//   Results leave in transfer order; the receiver cannot stall them.
//   A zero vector raises zero_vector_o with the unit vector and length outputs zero.
//   Reset clears the valid bits of the pipeline, dropping vectors in
//   flight; no configuration exists.
// ----------------------------------------------------------------------------
module vector_normalize_top #(
  parameter int MAX_COMPONENTS  = 4,
  parameter int COMPONENT_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [vn_pkg::CNT_WIDTH-1:0]        component_count_i,
  input  logic signed [vn_pkg::IN_WIDTH-1:0]  comp_x_i,
  input  logic signed [vn_pkg::IN_WIDTH-1:0]  comp_y_i,
  input  logic signed [vn_pkg::IN_WIDTH-1:0]  comp_z_i,
  input  logic signed [vn_pkg::IN_WIDTH-1:0]  comp_w_i,
  output logic                                done_o,
  output logic signed [vn_pkg::OUT_WIDTH-1:0] norm_x_o,
  output logic signed [vn_pkg::OUT_WIDTH-1:0] norm_y_o,
  output logic signed [vn_pkg::OUT_WIDTH-1:0] norm_z_o,
  output logic signed [vn_pkg::OUT_WIDTH-1:0] norm_w_o,
  output logic [vn_pkg::LEN_WIDTH-1:0]        length_out_o,
  output logic                                zero_vector_o
);

  localparam int CW   = COMPONENT_WIDTH;
  localparam int NL   = MAX_COMPONENTS;
  localparam int SW   = 2 * CW + 1;
  localparam int QB   = vn_pkg::QUO_BITS;
  localparam int NB   = (CW + 1 > (QB + 1) / 2) ? CW + 1 : (QB + 1) / 2;
  localparam int RW   = 2 * NB;
  localparam int NSTG = QB + NB;
  localparam int OW   = vn_pkg::OUT_WIDTH;
  localparam int LIM  = (NL < vn_pkg::MAX_COUNT) ? NL : vn_pkg::MAX_COUNT;
  localparam logic [vn_pkg::CNT_WIDTH-1:0] LIMIT_C = vn_pkg::CNT_WIDTH'(LIM);
  localparam logic [vn_pkg::CNT_WIDTH-1:0] MIN_C   =
    vn_pkg::CNT_WIDTH'(vn_pkg::MIN_COUNT);

  typedef struct packed {
    logic          zero;
    logic [NL-1:0] neg;
  } ctl_t;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // input decode
  logic [vn_pkg::CNT_WIDTH-1:0] cnt;
  logic [vn_pkg::IN_WIDTH-1:0]  comp_in [vn_pkg::NUM_LANES];
  logic [CW-1:0]                mag_d   [NL];
  logic [NL-1:0]                neg_d;

  assign comp_in[0] = comp_x_i;
  assign comp_in[1] = comp_y_i;
  assign comp_in[2] = comp_z_i;
  assign comp_in[3] = comp_w_i;

  always_comb begin
    cnt = component_count_i;
    if (cnt < MIN_C) begin
      cnt = MIN_C;
    end else if (cnt > LIMIT_C) begin
      cnt = LIMIT_C;
    end
  end

  for (genvar i = 0; i < NL; i++) begin : g_dec
    logic [CW-1:0] v;
    logic          used;
    assign v        = comp_in[i][CW-1:0];
    assign used     = vn_pkg::CNT_WIDTH'(i) < cnt;
    assign neg_d[i] = used && v[CW-1];
    assign mag_d[i] = !used ? '0 : (v[CW-1] ? (~v + 1'b1) : v);
  end

  // front stages: magnitude, square, pair sums, total
  logic                v0_q, v1_q, v2_q, v3_q;
  logic [CW-1:0]       mag0_q  [NL];
  logic [NL-1:0]       neg0_q, neg1_q, neg2_q, neg3_q;
  logic [SW-1:0]       sq1_q   [NL];
  logic [SW-1:0]       sq2_q   [NL];
  logic [SW-1:0]       sq3_q   [NL];
  logic [SW-1:0]       pair_d  [2];
  logic [SW-1:0]       pair_q  [2];
  logic [SW-1:0]       s_q;

  always_comb begin
    pair_d[0] = '0;
    pair_d[1] = '0;
    for (int k = 0; k < NL; k++) begin
      pair_d[k >> 1] = pair_d[k >> 1] + sq1_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= accept;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  for (genvar i = 0; i < NL; i++) begin : g_front
    logic [2*CW-1:0] prod;
    assign prod = mag0_q[i] * mag0_q[i];
    always_ff @(posedge clk_i) begin
      mag0_q[i] <= mag_d[i];
      sq1_q[i]  <= {1'b0, prod};
      sq2_q[i]  <= sq1_q[i];
      sq3_q[i]  <= sq2_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    neg0_q    <= neg_d;
    neg1_q    <= neg0_q;
    neg2_q    <= neg1_q;
    neg3_q    <= neg2_q;
    pair_q[0] <= pair_d[0];
    pair_q[1] <= pair_d[1];
    s_q       <= pair_q[0] + pair_q[1];
  end

  // control travels beside the cell chains
  logic [NSTG-1:0] vld_q;
  ctl_t            ctl_q [NSTG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-2:0], v3_q};
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q[0] <= '{zero: (s_q == '0), neg: neg3_q};
    for (int k = 1; k < NSTG; k++) begin
      ctl_q[k] <= ctl_q[k-1];
    end
  end

  // division lanes: floor(mag^2 * 2^60 / s)
  logic [SW-1:0] rem_c [NL][QB];
  logic [QB-1:0] quo_c [NL][QB];
  logic [SW-1:0] dv_c  [NL][QB];

  // sqrt lanes, the extra lane gives the length
  logic [RW-1:0]   rad_c  [NL+1][NB+1];
  logic [NB+1:0]   srem_c [NL+1][NB+1];
  logic [NB-1:0]   root_c [NL+1][NB+1];

  for (genvar i = 0; i < NL; i++) begin : g_div
    logic          top_fits;
    assign top_fits = sq3_q[i] >= s_q;

    // leading quotient bit, set only when the component is the whole length
    always_ff @(posedge clk_i) begin
      rem_c[i][0] <= top_fits ? (sq3_q[i] - s_q) : sq3_q[i];
      quo_c[i][0] <= QB'(top_fits);
      dv_c[i][0]  <= s_q;
    end

    for (genvar k = 0; k < QB - 1; k++) begin : g_cell
      vn_div_cell #(.SW(SW), .QB(QB)) u_cell (
        .clk_i (clk_i),
        .rem_i (rem_c[i][k]),
        .quo_i (quo_c[i][k]),
        .div_i (dv_c[i][k]),
        .rem_o (rem_c[i][k+1]),
        .quo_o (quo_c[i][k+1]),
        .div_o (dv_c[i][k+1])
      );
    end

    assign rad_c[i][0] = RW'(quo_c[i][QB-1]);
  end

  assign rad_c[NL][0] = RW'(dv_c[0][QB-1]);

  for (genvar i = 0; i <= NL; i++) begin : g_sqrt
    assign srem_c[i][0] = '0;
    assign root_c[i][0] = '0;
    for (genvar k = 0; k < NB; k++) begin : g_cell
      vn_sqrt_cell #(.NB(NB)) u_cell (
        .clk_i  (clk_i),
        .rad_i  (rad_c[i][k]),
        .rem_i  (srem_c[i][k]),
        .root_i (root_c[i][k]),
        .rad_o  (rad_c[i][k+1]),
        .rem_o  (srem_c[i][k+1]),
        .root_o (root_c[i][k+1])
      );
    end
  end

  // output register
  logic                          done_q;
  logic [OW-1:0]                 norm_q [vn_pkg::NUM_LANES];
  logic [vn_pkg::LEN_WIDTH-1:0]  len_q;
  logic                          zero_q;
  ctl_t                          last;

  assign last = ctl_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[NSTG-1];
    end
  end

  for (genvar i = 0; i < vn_pkg::NUM_LANES; i++) begin : g_out
    if (i < NL) begin : g_used
      logic [OW-1:0] q;
      assign q = OW'(root_c[i][NB]);
      always_ff @(posedge clk_i) begin
        norm_q[i] <= last.zero ? '0 : (last.neg[i] ? (~q + 1'b1) : q);
      end
    end else begin : g_none
      always_ff @(posedge clk_i) begin
        norm_q[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= last.zero ? '0 : vn_pkg::LEN_WIDTH'(root_c[NL][NB]);
    zero_q <= last.zero;
  end

  assign done_o        = done_q;
  assign norm_x_o      = norm_q[0];
  assign norm_y_o      = norm_q[1];
  assign norm_z_o      = norm_q[2];
  assign norm_w_o      = norm_q[3];
  assign length_out_o  = len_q;
  assign zero_vector_o = zero_q;

endmodule

// File: sim/vector_normalize_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_normalize_top_test
// Drives 2 to 4 component Q16.16 vectors into the normalize block. A
// bit-exact integer predictor computes the expected unit vector, magnitude
// and zero flag. Results are checked in transfer order under several
// sender idle patterns.
// ----------------------------------------------------------------------------
module vector_normalize_top_test;

  typedef logic signed [vn_pkg::IN_WIDTH-1:0] comp_vec_t [vn_pkg::NUM_LANES];

  typedef struct packed {
    logic signed [vn_pkg::OUT_WIDTH-1:0] nx;
    logic signed [vn_pkg::OUT_WIDTH-1:0] ny;
    logic signed [vn_pkg::OUT_WIDTH-1:0] nz;
    logic signed [vn_pkg::OUT_WIDTH-1:0] nw;
    logic [vn_pkg::LEN_WIDTH-1:0]        len;
    logic                                zero;
  } unit_vec_t;

  // exact integer normalization, same rounding as the block
  function automatic unit_vec_t normalize_vec(logic [vn_pkg::CNT_WIDTH-1:0] cnt,
                                              comp_vec_t c);
    unit_vec_t                    res;
    int                           used;
    logic [127:0]                 mag [vn_pkg::NUM_LANES];
    logic [127:0]                 sum, root, t, q, rhs;
    logic [vn_pkg::OUT_WIDTH-1:0] lane [vn_pkg::NUM_LANES];
    used = int'(cnt);
    if (used < vn_pkg::MIN_COUNT) used = vn_pkg::MIN_COUNT;
    if (used > vn_pkg::MAX_COUNT) used = vn_pkg::MAX_COUNT;
    sum = '0;
    for (int i = 0; i < vn_pkg::NUM_LANES; i++) begin
      mag[i] = c[i][vn_pkg::IN_WIDTH-1] ? 128'(-64'(signed'(c[i]))) : 128'(c[i]);
      lane[i] = '0;
      if (i < used) sum += mag[i] * mag[i];
    end
    res = '0;
    if (sum == 0) begin
      res.zero = 1'b1;
      return res;
    end
    root = '0;
    for (int b = 32; b >= 0; b--) begin
      t = root | (128'd1 << b);
      if (t * t <= sum) root = t;
    end
    for (int i = 0; i < used; i++) begin
      rhs = (mag[i] * mag[i]) << 60;
      q = '0;
      for (int b = 30; b >= 0; b--) begin
        t = q | (128'd1 << b);
        if (t * t * sum <= rhs) q = t;
      end
      lane[i] = c[i][vn_pkg::IN_WIDTH-1] ? vn_pkg::OUT_WIDTH'(-q) : vn_pkg::OUT_WIDTH'(q);
    end
    res.nx = lane[0];
    res.ny = lane[1];
    res.nz = lane[2];
    res.nw = lane[3];
    res.len = vn_pkg::LEN_WIDTH'(root);
    return res;
  endfunction

  class unit_vec_board;
    unit_vec_t pending[$];
    int        errors = 0;

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
      errors++;
    endtask

    function void note_vector(logic [vn_pkg::CNT_WIDTH-1:0] cnt, comp_vec_t c);
      pending.push_back(normalize_vec(cnt, c));
    endfunction

    task check_result(unit_vec_t got);
      unit_vec_t want;
      if (pending.size() == 0) begin
        report("unexpected result", 64'(got.len), 64'h0);
        return;
      end
      want = pending.pop_front();
      if (got.nx !== want.nx) report("norm_x", 64'(got.nx), 64'(want.nx));
      if (got.ny !== want.ny) report("norm_y", 64'(got.ny), 64'(want.ny));
      if (got.nz !== want.nz) report("norm_z", 64'(got.nz), 64'(want.nz));
      if (got.nw !== want.nw) report("norm_w", 64'(got.nw), 64'(want.nw));
      if (got.len !== want.len) report("length_out", 64'(got.len), 64'(want.len));
      if (got.zero !== want.zero) report("zero_vector", 64'(got.zero), 64'(want.zero));
    endtask
  endclass

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic [vn_pkg::CNT_WIDTH-1:0]        component_count_i = '0;
  logic signed [vn_pkg::IN_WIDTH-1:0]  comp_x_i = '0, comp_y_i = '0;
  logic signed [vn_pkg::IN_WIDTH-1:0]  comp_z_i = '0, comp_w_i = '0;
  logic                                done_o;
  logic signed [vn_pkg::OUT_WIDTH-1:0] norm_x_o, norm_y_o, norm_z_o, norm_w_o;
  logic [vn_pkg::LEN_WIDTH-1:0]        length_out_o;
  logic                                zero_vector_o;

  unit_vec_board board = new();
  int idle_pct = 0;
  int quiet_cycles = 0;
  localparam int QUIET_LIMIT = 3000;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  vector_normalize_top i_dut (
    .clk_i, .rst_ni, .start, .busy, .component_count_i,
    .comp_x_i, .comp_y_i, .comp_z_i, .comp_w_i,
    .done_o, .norm_x_o, .norm_y_o, .norm_z_o, .norm_w_o,
    .length_out_o, .zero_vector_o
  );

  // sample both sides at the edge; drivers only update after it
  always @(posedge clk_i) begin
    comp_vec_t c;
    unit_vec_t got;
    logic      moved;
    moved = 1'b0;
    if (rst_ni && start && !busy) begin
      c[0] = comp_x_i; c[1] = comp_y_i; c[2] = comp_z_i; c[3] = comp_w_i;
      board.note_vector(component_count_i, c);
      moved = 1'b1;
    end
    if (rst_ni && done_o) begin
      got = '{norm_x_o, norm_y_o, norm_z_o, norm_w_o, length_out_o, zero_vector_o};
      board.check_result(got);
      moved = 1'b1;
    end
    if (moved) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("vector_normalize_top_test failed");
      $finish;
    end
  end

  task automatic send_vector(logic [vn_pkg::CNT_WIDTH-1:0] cnt, logic [31:0] x,
                             logic [31:0] y, logic [31:0] z, logic [31:0] w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    component_count_i <= cnt;
    comp_x_i <= x; comp_y_i <= y; comp_z_i <= z; comp_w_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_comp();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'(signed'($urandom_range(20)) - 10);
      4, 5: return 32'(signed'($urandom_range(32'h0003_ffff)) - 32'sh0002_0000);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int                           phase_idle [4];
    logic [vn_pkg::CNT_WIDTH-1:0] cnt;
    phase_idle = '{0, 84, 0, 36};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    for (int n = 0; n < 8; n++) begin
      send_vector(vn_pkg::CNT_WIDTH'(n), 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                  32'h7fff_ffff);
    end
    // zero in used lanes only
    send_vector(3'd2, 32'h0, 32'h0, 32'h1234, 32'h5678);
    send_vector(3'd4, 32'h0, 32'h0, 32'h0, 32'h0);
    send_vector(3'd4, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(3'd4, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    // full-length component
    send_vector(3'd3, 32'h8000_0000, 32'h0, 32'h0, 32'hffff_ffff);
    send_vector(3'd2, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
    send_vector(3'd4, 32'h0, 32'h0, 32'h0, 32'hffff_ffff);
    send_vector(3'd3, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 32'h0);
    send_vector(3'd2, 32'h0003_0000, 32'hfffc_0000, 32'h0, 32'h0);
    send_vector(3'd4, 32'h5555_5555, 32'haaaa_aaaa, 32'h3333_3333, 32'hcccc_cccc);
    drain_results();

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      for (int k = 0; k < 150; k++) begin
        cnt = ($urandom_range(9) == 0) ? vn_pkg::CNT_WIDTH'($urandom())
                                       : vn_pkg::CNT_WIDTH'($urandom_range(2, 4));
        if ($urandom_range(29) == 0)
          send_vector(cnt, 32'h0, 32'h0, $urandom(), $urandom());
        else
          send_vector(cnt, random_comp(), random_comp(), random_comp(), random_comp());
      end
      // hold off until everything in flight has come back
      drain_results();
    end

    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("vector_normalize_top_test passed");
    end else begin
      $display("vector_normalize_top_test failed");
    end
    $finish;
  end

endmodule
